### hdl/lppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types and constants of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

   localparam int STORE_DEPTH = 16;
   localparam int STORE_AW    = 4;
   localparam int LEN_W       = 16;
   localparam int CSR_AW      = 2;
   localparam int CSR_DW      = 32;

   localparam logic [LEN_W-1:0] MAX_TOTAL_RESET = 16'd29000;

   localparam logic [CSR_AW-1:0] CSR_MAX_TOTAL_LENGTH = 2'd0;

   localparam logic [1:0] STATUS_PACKET = 2'd0;
   localparam logic [1:0] STATUS_SHORT  = 2'd1;
   localparam logic [1:0] STATUS_LONG   = 2'd2;

   typedef enum logic [1:0] {
      SRC_HDR,
      SRC_REJ,
      SRC_BODY
   } out_src_type;

   typedef struct packed {
      logic        hdr_wr;
      logic        idx_clr;
      logic        body_load;
      logic        out_load;
      out_src_type out_src;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hdr_last;
      logic too_short;
      logic too_long;
      logic emit_last;
      logic hdr_only;
      logic body_fin;
      logic out_free;
   } ctrl_stat_type;

endpackage

### hdl/lppd_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_csr
// APB-style register port holding the maximum total packet length.
// ----------------------------------------------------------------------------
module lppd_csr
   import lppd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output logic [LEN_W-1:0]  max_total_length
);

   logic [LEN_W-1:0] max_total_ff;
   logic [LEN_W-1:0] max_total_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      max_total_in = max_total_ff;
      if (wr_en && paddr == CSR_MAX_TOTAL_LENGTH) begin
         max_total_in = pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_total_ff <= MAX_TOTAL_RESET;
      end else begin
         max_total_ff <= max_total_in;
      end
   end

   always_comb begin
      case (paddr)
         CSR_MAX_TOTAL_LENGTH: prdata = {{(CSR_DW-LEN_W){1'b0}}, max_total_ff};
         default:              prdata = '0;
      endcase
   end

   assign max_total_length = max_total_ff;

endmodule

### hdl/lppd_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_dpath
// Header store, counters, length check and registered result stage.
// ----------------------------------------------------------------------------
module lppd_dpath
   import lppd_pkg::*;
#(
   parameter int HDR_LEN    = 8,
   parameter int LEN_OFFSET = 0
)
(
   input  logic             clock,
   input  logic             reset,
   input  ctrl_cmd_type     cmd,
   output ctrl_stat_type    stat,
   input  logic [7:0]       rx_byte,
   input  logic [LEN_W-1:0] max_total_length,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic [1:0]       rsp_status
);

   localparam logic [STORE_AW-1:0] HDR_END = STORE_AW'(HDR_LEN - 1);
   localparam logic [STORE_AW-1:0] HI_IDX  = STORE_AW'(LEN_OFFSET);
   localparam logic [STORE_AW-1:0] LO_IDX  = STORE_AW'(LEN_OFFSET + 1);
   localparam logic [LEN_W-1:0]    HDR_TOT = LEN_W'(HDR_LEN);

   logic [7:0]          store_ff [STORE_DEPTH];
   logic [STORE_AW-1:0] count_ff;
   logic [STORE_AW-1:0] idx_ff;
   logic [LEN_W-1:0]    rem_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [7:0]          out_byte_ff;
   logic                out_last_ff;
   logic [1:0]          out_status_ff;
   logic [LEN_W-1:0]    total;

   assign total = {store_ff[HI_IDX], store_ff[LO_IDX]};

   assign stat.hdr_last  = (count_ff == HDR_END);
   assign stat.too_short = (total < HDR_TOT);
   assign stat.too_long  = (total > max_total_length);
   assign stat.emit_last = (idx_ff == HDR_END);
   assign stat.hdr_only  = (total == HDR_TOT);
   assign stat.body_fin  = (rem_ff <= LEN_W'(1));
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.hdr_wr) begin
         store_ff[count_ff] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
         rem_ff   <= '0;
      end else begin
         if (cmd.hdr_wr) begin
            count_ff <= stat.hdr_last ? '0 : count_ff + STORE_AW'(1);
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.out_load && cmd.out_src == SRC_HDR) begin
            idx_ff <= idx_ff + STORE_AW'(1);
         end
         if (cmd.body_load) begin
            rem_ff <= total - HDR_TOT;
         end else if (cmd.out_load && cmd.out_src == SRC_BODY) begin
            rem_ff <= stat.body_fin ? '0 : rem_ff - LEN_W'(1);
         end
      end
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         case (cmd.out_src)
            SRC_HDR: begin
               out_byte_ff   <= store_ff[idx_ff];
               out_last_ff   <= stat.emit_last && stat.hdr_only;
               out_status_ff <= STATUS_PACKET;
            end
            SRC_REJ: begin
               out_byte_ff   <= 8'd0;
               out_last_ff   <= 1'b0;
               out_status_ff <= stat.too_short ? STATUS_SHORT : STATUS_LONG;
            end
            SRC_BODY: begin
               out_byte_ff   <= rx_byte;
               out_last_ff   <= stat.body_fin;
               out_status_ff <= STATUS_PACKET;
            end
            default: begin
               out_byte_ff   <= 8'd0;
               out_last_ff   <= 1'b0;
               out_status_ff <= STATUS_PACKET;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_status   = out_status_ff;

endmodule

### hdl/lppd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_ctrl
// Sequencer: header collection, length check, header replay, body pass.
// ----------------------------------------------------------------------------
module lppd_ctrl
   import lppd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_HDR   = 5'b00001,
      S_CHECK = 5'b00010,
      S_REJ   = 5'b00100,
      S_EMIT  = 5'b01000,
      S_BODY  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_comb begin
      case (state_ff)
         S_HDR:   req_stall = 1'b0;
         S_BODY:  req_stall = !stat.out_free;
         default: req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      cmd.hdr_wr    = 1'b0;
      cmd.idx_clr   = 1'b0;
      cmd.body_load = 1'b0;
      cmd.out_load  = 1'b0;
      cmd.out_src   = SRC_HDR;
      case (state_ff)
         S_HDR: begin
            cmd.hdr_wr = accept;
            if (accept && stat.hdr_last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.idx_clr   = 1'b1;
            cmd.body_load = 1'b1;
            state_in      = (stat.too_short || stat.too_long) ? S_REJ : S_EMIT;
         end
         S_REJ: begin
            cmd.out_src = SRC_REJ;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_HDR;
            end
         end
         S_EMIT: begin
            cmd.out_src = SRC_HDR;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               if (stat.emit_last) begin
                  state_in = stat.hdr_only ? S_HDR : S_BODY;
               end
            end
         end
         S_BODY: begin
            cmd.out_src  = SRC_BODY;
            cmd.out_load = accept;
            if (accept && stat.body_fin) begin
               state_in = S_HDR;
            end
         end
         default: begin
            state_in = S_HDR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HDR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/length_prefixed_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Splits a byte stream into packets framed by a header carrying a
// big-endian 16-bit total length; rejects out-of-range lengths.
// ----------------------------------------------------------------------------
// Header bytes are taken one per cycle and produce nothing. After the last
// header byte the sequencer checks the length in its S_CHECK state, then
// sends either one discard result or HDR_LEN header results from the
// header store, one per cycle while the result channel does not stall.
// Body bytes then pass one per cycle through the output register while
// the result channel does not stall. The input is held off during the
// check and the header replay of an accepted packet, and during the
// check and the discard result of a rejected header.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer
   import lppd_pkg::*;
#(
   parameter int HDR_LEN    = 8,
   parameter int LEN_OFFSET = 0
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last,
   output logic [1:0]        rsp_status,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   ctrl_cmd_type     cmd;
   ctrl_stat_type    stat;
   logic [LEN_W-1:0] max_total_length;

   lppd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .max_total_length (max_total_length)
   );

   lppd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lppd_dpath #(
      .HDR_LEN    (HDR_LEN),
      .LEN_OFFSET (LEN_OFFSET)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .rx_byte          (req_rx_byte),
      .max_total_length (max_total_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status)
   );

endmodule
